// File: hdl/rdp_pkg.sv
// shared types, constants and saturating add/subtract for the
// response diagonal preconditioner; no dependencies
`timescale 1ns / 1ps

package rdp_pkg;

    localparam int DW      = 32;
    localparam int FB      = 20;
    localparam int CFG_IW  = 2;
    localparam int MUL_LAT = 2;
    localparam int DIV_LAT = DW + 2;

    typedef logic signed [DW-1:0]   word_t;
    typedef logic signed [2*DW-1:0] prod_t;

    typedef struct packed {
        logic  sat;
        word_t val;
    } res_t;

    localparam word_t MAX_VAL = {1'b0, {(DW-1){1'b1}}};
    localparam word_t MIN_VAL = {1'b1, {(DW-1){1'b0}}};
    localparam word_t ONE_VAL = (FB >= DW - 1) ? MAX_VAL : word_t'(prod_t'(1) <<< FB);

    localparam logic [1:0] MODE_ONE  = 2'd0;
    localparam logic [1:0] MODE_TWO  = 2'd1;
    localparam logic [1:0] MODE_FOUR = 2'd2;

    localparam logic [CFG_IW-1:0] REG_FREQ = 2'd0;
    localparam logic [CFG_IW-1:0] REG_DAMP = 2'd1;
    localparam logic [CFG_IW-1:0] REG_MODE = 2'd2;

    function automatic res_t sat_add(input word_t a, input word_t b);
        logic [DW:0] s;
        res_t r;
        s = {a[DW-1], a} + {b[DW-1], b};
        r.sat = s[DW] != s[DW-1];
        r.val = r.sat ? (s[DW] ? MIN_VAL : MAX_VAL) : word_t'(s[DW-1:0]);
        return r;
    endfunction

    function automatic res_t sat_sub(input word_t a, input word_t b);
        logic [DW:0] s;
        res_t r;
        s = {a[DW-1], a} - {b[DW-1], b};
        r.sat = s[DW] != s[DW-1];
        r.val = r.sat ? (s[DW] ? MIN_VAL : MAX_VAL) : word_t'(s[DW-1:0]);
        return r;
    endfunction

endpackage

// File: hdl/response_diagonal_preconditioner.sv
// response diagonal preconditioner top level: config registers and the
// fixed schedule of dividers, multipliers and saturating adds
// depends on rdp_pkg, rdp_mul, rdp_div
// the result strobe done is the request passed along the vld_reg delay line, then registered
// throughput: one request per cycle, busy stays low, no stall from the receiver
// the longest path is the chain of six dependent dividers of DW + 2 stages each
// reset clears config registers and the valid line; no clearing pass
`timescale 1ns / 1ps

module response_diagonal_preconditioner
    import rdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [DW-1:0]     cfg_data,
    input  word_t             diag_entry,
    input  word_t             rhs0,
    input  word_t             rhs1,
    input  word_t             rhs2,
    input  word_t             rhs3,
    output logic              done,
    output word_t             out0,
    output word_t             out1,
    output word_t             out2,
    output word_t             out3,
    output logic              singular
);

    localparam int T_S0  = 1;
    localparam int T_Q0  = T_S0 + DIV_LAT;
    localparam int T_O0  = T_Q0 + MUL_LAT;
    localparam int T_Q1  = DIV_LAT;
    localparam int T_M1  = T_Q1 + MUL_LAT;
    localparam int T_S1  = T_M1 + 1;
    localparam int T_A   = T_S1 + DIV_LAT;
    localparam int T_AW  = T_A + MUL_LAT;
    localparam int T_B   = T_AW + DIV_LAT;
    localparam int T_AGG = T_AW + MUL_LAT;
    localparam int T_C   = T_AGG + 1;
    localparam int T_P1  = T_B + MUL_LAT;
    localparam int T_R1  = T_P1 + 1;
    localparam int T_BGG = T_P1 + MUL_LAT;
    localparam int T_M   = T_BGG + 1;
    localparam int T_Q2  = T_M + DIV_LAT;
    localparam int T_MM  = T_Q2 + MUL_LAT;
    localparam int T_S2  = T_MM + 1;
    localparam int T_E   = T_S2 + DIV_LAT;
    localparam int T_NE  = T_E + 1;
    localparam int T_NEM = T_NE + MUL_LAT;
    localparam int T_F   = T_NEM + DIV_LAT;
    localparam int T_X1  = T_F + MUL_LAT;
    localparam int T_X2  = T_X1 + MUL_LAT;
    localparam int T_PH  = T_X2 + 1;
    localparam int T_NPH = T_PH + 1;
    localparam int T_DP  = T_NPH + MUL_LAT;
    localparam int T_D1  = T_DP + 1;
    localparam int T_D2  = T_D1 + 1;
    localparam int T_END = T_D2 + 1;

    localparam int D_LEN = T_AGG;
    localparam int R_LEN = T_NPH;
    localparam int O_LEN = T_END - T_O0;
    localparam int A_LEN = T_F - T_A;
    localparam int B_LEN = T_F - T_B;
    localparam int T_LEN = T_END - T_R1;
    localparam int C_LEN = T_NEM - T_C;
    localparam int M_LEN = T_NE - T_M;
    localparam int E_LEN = T_NPH - T_E;
    localparam int F_LEN = T_NPH - T_F;

    // config
    word_t      freq_reg;
    word_t      damp_reg;
    logic [1:0] mode_reg;
    word_t      w_eff;
    res_t       nw;
    logic       md0;
    logic       md1;
    logic       md2;
    logic       md12;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= '0;
            damp_reg <= '0;
            mode_reg <= MODE_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FREQ: freq_reg <= word_t'(cfg_data);
                REG_DAMP: damp_reg <= word_t'(cfg_data);
                REG_MODE: mode_reg <= cfg_data[1:0];
                default:  ;
            endcase
        end
    end

    assign w_eff = (freq_reg == '0) ? word_t'(1) : freq_reg;
    assign nw    = sat_sub('0, w_eff);
    assign md0   = mode_reg == MODE_ONE;
    assign md1   = mode_reg == MODE_TWO;
    assign md2   = mode_reg == MODE_FOUR;
    assign md12  = md1 || md2;
    assign busy  = 1'b0;

    // request capture and delay lines
    logic  vld_reg [0:T_END];
    logic  sat_reg [0:T_END];
    logic [T_END:0] ins;
    word_t d_in_reg;
    word_t r_in_reg  [4];
    word_t d_dly_reg [1:D_LEN];
    word_t r_dly_reg [4][1:R_LEN];
    word_t o0_dly_reg [1:O_LEN];
    word_t a_dly_reg [1:A_LEN];
    word_t b_dly_reg [1:B_LEN];
    word_t t0_dly_reg [1:T_LEN];
    word_t t1_dly_reg [1:T_LEN];
    word_t c_dly_reg [1:C_LEN];
    word_t m_dly_reg [1:M_LEN];
    word_t e_dly_reg [1:E_LEN];
    word_t f_dly_reg [1:F_LEN];
    word_t p_d_reg;
    word_t h_d_reg;

    // unit results
    res_t s0_reg, s1_reg, s2_reg, c_reg, m_reg, ne_reg;
    res_t t0_reg, t1_reg, p_reg, h_reg, np_reg, nh_reg;
    res_t q0, o0, q1, m1, a_r, aw, ag, b_r, agg;
    res_t ar0, br1, br0, ar1, bg, bgg, q2, mm, e_r, nem, f_r;
    res_t af, ae, be, bf, afg, aeg, beg, bfg;
    word_t coef [4][4];
    word_t r_at_dot [4];
    res_t  dprod [4][4];
    res_t  sum1_reg [4];
    res_t  sum2_reg [4];
    res_t  sum3_reg [4];
    res_t  dp2_reg  [4];
    res_t  dp3_reg  [4][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= T_END; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            done <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int k = 1; k <= T_END; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            done <= vld_reg[T_END];
        end
    end

    always_ff @(posedge clk)
    begin
        d_in_reg    <= diag_entry;
        r_in_reg[0] <= rhs0;
        r_in_reg[1] <= rhs1;
        r_in_reg[2] <= rhs2;
        r_in_reg[3] <= rhs3;
        sat_reg[0]  <= 1'b0;
        for (int k = 1; k <= T_END; k++)
        begin
            sat_reg[k] <= sat_reg[k-1] | ins[k-1];
        end
        d_dly_reg[1] <= d_in_reg;
        for (int k = 2; k <= D_LEN; k++)
        begin
            d_dly_reg[k] <= d_dly_reg[k-1];
        end
        for (int j = 0; j < 4; j++)
        begin
            r_dly_reg[j][1] <= r_in_reg[j];
            for (int k = 2; k <= R_LEN; k++)
            begin
                r_dly_reg[j][k] <= r_dly_reg[j][k-1];
            end
        end
        o0_dly_reg[1] <= o0.val;
        for (int k = 2; k <= O_LEN; k++)
        begin
            o0_dly_reg[k] <= o0_dly_reg[k-1];
        end
        a_dly_reg[1] <= a_r.val;
        for (int k = 2; k <= A_LEN; k++)
        begin
            a_dly_reg[k] <= a_dly_reg[k-1];
        end
        b_dly_reg[1] <= b_r.val;
        for (int k = 2; k <= B_LEN; k++)
        begin
            b_dly_reg[k] <= b_dly_reg[k-1];
        end
        t0_dly_reg[1] <= t0_reg.val;
        t1_dly_reg[1] <= t1_reg.val;
        for (int k = 2; k <= T_LEN; k++)
        begin
            t0_dly_reg[k] <= t0_dly_reg[k-1];
            t1_dly_reg[k] <= t1_dly_reg[k-1];
        end
        c_dly_reg[1] <= c_reg.val;
        for (int k = 2; k <= C_LEN; k++)
        begin
            c_dly_reg[k] <= c_dly_reg[k-1];
        end
        m_dly_reg[1] <= m_reg.val;
        for (int k = 2; k <= M_LEN; k++)
        begin
            m_dly_reg[k] <= m_dly_reg[k-1];
        end
        e_dly_reg[1] <= e_r.val;
        for (int k = 2; k <= E_LEN; k++)
        begin
            e_dly_reg[k] <= e_dly_reg[k-1];
        end
        f_dly_reg[1] <= f_r.val;
        for (int k = 2; k <= F_LEN; k++)
        begin
            f_dly_reg[k] <= f_dly_reg[k-1];
        end
        p_d_reg <= p_reg.val;
        h_d_reg <= h_reg.val;

        // saturating add/subtract stages
        s0_reg <= sat_sub(w_eff, d_in_reg);
        s1_reg <= sat_sub(d_dly_reg[T_M1], m1.val);
        c_reg  <= sat_add(d_dly_reg[T_AGG], agg.val);
        t0_reg <= sat_add(ar0.val, br1.val);
        t1_reg <= sat_add(br0.val, ar1.val);
        m_reg  <= sat_add(nw.val, bgg.val);
        s2_reg <= sat_sub(c_dly_reg[T_MM - T_C], mm.val);
        ne_reg <= sat_sub('0, e_r.val);
        p_reg  <= sat_add(afg.val, beg.val);
        h_reg  <= sat_add(aeg.val, bfg.val);
        np_reg <= sat_sub('0, p_reg.val);
        nh_reg <= sat_sub('0, h_reg.val);
        for (int i = 0; i < 4; i++)
        begin
            sum1_reg[i]   <= sat_add(dprod[i][0].val, dprod[i][1].val);
            dp2_reg[i]    <= dprod[i][2];
            dp3_reg[i][0] <= dprod[i][3];
            dp3_reg[i][1] <= dp3_reg[i][0];
            sum2_reg[i]   <= sat_add(sum1_reg[i].val, dp2_reg[i].val);
            sum3_reg[i]   <= sat_add(sum2_reg[i].val, dp3_reg[i][1].val);
        end
    end

    // one set
    rdp_div u_q0  (.clk(clk), .num(ONE_VAL), .den(s0_reg.val), .res(q0));
    rdp_mul u_o0  (.clk(clk), .a(q0.val), .b(r_dly_reg[0][T_Q0]), .res(o0));

    // two and four sets: a and b
    rdp_div u_q1  (.clk(clk), .num(w_eff), .den(d_in_reg), .res(q1));
    rdp_mul u_m1  (.clk(clk), .a(q1.val), .b(w_eff), .res(m1));
    rdp_div u_a   (.clk(clk), .num(ONE_VAL), .den(s1_reg.val), .res(a_r));
    rdp_mul u_aw  (.clk(clk), .a(a_r.val), .b(w_eff), .res(aw));
    rdp_mul u_ag  (.clk(clk), .a(a_r.val), .b(damp_reg), .res(ag));
    rdp_div u_b   (.clk(clk), .num(aw.val), .den(d_dly_reg[T_AW]), .res(b_r));

    // two sets
    rdp_mul u_ar0 (.clk(clk), .a(a_dly_reg[T_B - T_A]), .b(r_dly_reg[0][T_B]), .res(ar0));
    rdp_mul u_br1 (.clk(clk), .a(b_r.val), .b(r_dly_reg[1][T_B]), .res(br1));
    rdp_mul u_br0 (.clk(clk), .a(b_r.val), .b(r_dly_reg[0][T_B]), .res(br0));
    rdp_mul u_ar1 (.clk(clk), .a(a_dly_reg[T_B - T_A]), .b(r_dly_reg[1][T_B]), .res(ar1));

    // four sets: c, m, e, f
    rdp_mul u_agg (.clk(clk), .a(ag.val), .b(damp_reg), .res(agg));
    rdp_mul u_bg  (.clk(clk), .a(b_r.val), .b(damp_reg), .res(bg));
    rdp_mul u_bgg (.clk(clk), .a(bg.val), .b(damp_reg), .res(bgg));
    rdp_div u_q2  (.clk(clk), .num(m_reg.val), .den(c_dly_reg[T_M - T_C]), .res(q2));
    rdp_mul u_mm  (.clk(clk), .a(q2.val), .b(m_dly_reg[T_Q2 - T_M]), .res(mm));
    rdp_div u_e   (.clk(clk), .num(ONE_VAL), .den(s2_reg.val), .res(e_r));
    rdp_mul u_nem (.clk(clk), .a(ne_reg.val), .b(m_dly_reg[T_NE - T_M]), .res(nem));
    rdp_div u_f   (.clk(clk), .num(nem.val), .den(c_dly_reg[T_NEM - T_C]), .res(f_r));

    // four sets: p and h
    rdp_mul u_af  (.clk(clk), .a(a_dly_reg[T_F - T_A]), .b(f_r.val), .res(af));
    rdp_mul u_ae  (.clk(clk), .a(a_dly_reg[T_F - T_A]), .b(e_dly_reg[T_F - T_E]), .res(ae));
    rdp_mul u_be  (.clk(clk), .a(b_dly_reg[T_F - T_B]), .b(e_dly_reg[T_F - T_E]), .res(be));
    rdp_mul u_bf  (.clk(clk), .a(b_dly_reg[T_F - T_B]), .b(f_r.val), .res(bf));
    rdp_mul u_afg (.clk(clk), .a(af.val), .b(damp_reg), .res(afg));
    rdp_mul u_aeg (.clk(clk), .a(ae.val), .b(damp_reg), .res(aeg));
    rdp_mul u_beg (.clk(clk), .a(be.val), .b(damp_reg), .res(beg));
    rdp_mul u_bfg (.clk(clk), .a(bf.val), .b(damp_reg), .res(bfg));

    // four sets: block product
    always_comb
    begin
        coef[0][0] = e_dly_reg[E_LEN];
        coef[0][1] = f_dly_reg[F_LEN];
        coef[0][2] = np_reg.val;
        coef[0][3] = nh_reg.val;
        coef[1][0] = f_dly_reg[F_LEN];
        coef[1][1] = e_dly_reg[E_LEN];
        coef[1][2] = nh_reg.val;
        coef[1][3] = np_reg.val;
        coef[2][0] = p_d_reg;
        coef[2][1] = h_d_reg;
        coef[2][2] = e_dly_reg[E_LEN];
        coef[2][3] = f_dly_reg[F_LEN];
        coef[3][0] = h_d_reg;
        coef[3][1] = p_d_reg;
        coef[3][2] = f_dly_reg[F_LEN];
        coef[3][3] = e_dly_reg[E_LEN];
        for (int j = 0; j < 4; j++)
        begin
            r_at_dot[j] = r_dly_reg[j][R_LEN];
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_row
        for (genvar j = 0; j < 4; j++)
        begin : g_col
            rdp_mul u_dot (.clk(clk), .a(coef[i][j]), .b(r_at_dot[j]), .res(dprod[i][j]));
        end
    end

    // saturation flags, each at the stage its value lands
    always_comb
    begin
        ins = '0;
        ins[T_S0]  = ins[T_S0]  | (md0 & s0_reg.sat);
        ins[T_Q0]  = ins[T_Q0]  | (md0 & q0.sat);
        ins[T_O0]  = ins[T_O0]  | (md0 & o0.sat);
        ins[T_Q1]  = ins[T_Q1]  | (md12 & q1.sat);
        ins[T_M1]  = ins[T_M1]  | (md12 & m1.sat);
        ins[T_S1]  = ins[T_S1]  | (md12 & s1_reg.sat);
        ins[T_A]   = ins[T_A]   | (md12 & a_r.sat);
        ins[T_AW]  = ins[T_AW]  | (md12 & aw.sat) | (md2 & ag.sat);
        ins[T_B]   = ins[T_B]   | (md12 & b_r.sat);
        ins[T_P1]  = ins[T_P1]  | (md1 & (ar0.sat | br1.sat | br0.sat | ar1.sat))
                                | (md2 & bg.sat);
        ins[T_R1]  = ins[T_R1]  | (md1 & (t0_reg.sat | t1_reg.sat));
        ins[T_AGG] = ins[T_AGG] | (md2 & agg.sat);
        ins[T_C]   = ins[T_C]   | (md2 & c_reg.sat);
        ins[T_BGG] = ins[T_BGG] | (md2 & (bgg.sat | nw.sat));
        ins[T_M]   = ins[T_M]   | (md2 & m_reg.sat);
        ins[T_Q2]  = ins[T_Q2]  | (md2 & q2.sat);
        ins[T_MM]  = ins[T_MM]  | (md2 & mm.sat);
        ins[T_S2]  = ins[T_S2]  | (md2 & s2_reg.sat);
        ins[T_E]   = ins[T_E]   | (md2 & e_r.sat);
        ins[T_NE]  = ins[T_NE]  | (md2 & ne_reg.sat);
        ins[T_NEM] = ins[T_NEM] | (md2 & nem.sat);
        ins[T_F]   = ins[T_F]   | (md2 & f_r.sat);
        ins[T_X1]  = ins[T_X1]  | (md2 & (af.sat | ae.sat | be.sat | bf.sat));
        ins[T_X2]  = ins[T_X2]  | (md2 & (afg.sat | aeg.sat | beg.sat | bfg.sat));
        ins[T_PH]  = ins[T_PH]  | (md2 & (p_reg.sat | h_reg.sat));
        ins[T_NPH] = ins[T_NPH] | (md2 & (np_reg.sat | nh_reg.sat));
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                ins[T_DP] = ins[T_DP] | (md2 & dprod[i][j].sat);
            end
            ins[T_D1]  = ins[T_D1]  | (md2 & sum1_reg[i].sat);
            ins[T_D2]  = ins[T_D2]  | (md2 & sum2_reg[i].sat);
            ins[T_END] = ins[T_END] | (md2 & sum3_reg[i].sat);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        singular <= sat_reg[T_END] | ins[T_END];
        case (mode_reg)
            MODE_ONE:
            begin
                out0 <= o0_dly_reg[O_LEN];
                out1 <= '0;
                out2 <= '0;
                out3 <= '0;
            end
            MODE_TWO:
            begin
                out0 <= t0_dly_reg[T_LEN];
                out1 <= t1_dly_reg[T_LEN];
                out2 <= '0;
                out3 <= '0;
            end
            MODE_FOUR:
            begin
                out0 <= sum3_reg[0].val;
                out1 <= sum3_reg[1].val;
                out2 <= sum3_reg[2].val;
                out3 <= sum3_reg[3].val;
            end
            default:
            begin
                out0 <= '0;
                out1 <= '0;
                out2 <= '0;
                out3 <= '0;
            end
        endcase
    end

endmodule

// File: hdl/rdp_mul.sv
// two-stage saturating fixed-point multiplier, floor rounding
// depends on rdp_pkg
`timescale 1ns / 1ps

module rdp_mul
    import rdp_pkg::*;
(
    input  logic  clk,
    input  word_t a,
    input  word_t b,
    output res_t  res
);

    localparam int TW = DW - FB + 1;

    prod_t   prod_reg;
    res_t    res_reg;
    res_t    res_next;
    logic [TW-1:0] top;

    always_comb
    begin
        top = prod_reg[2*DW-1:FB+DW-1];
        res_next.sat = !((&top) || !(|top));
        if (res_next.sat)
        begin
            res_next.val = prod_reg[2*DW-1] ? MIN_VAL : MAX_VAL;
        end
        else
        begin
            res_next.val = word_t'(prod_reg[FB+DW-1:FB]);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_t'(a) * prod_t'(b);
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

// File: hdl/rdp_div.sv
// pipelined saturating fixed-point divider, one quotient bit per stage
// depends on rdp_pkg
`timescale 1ns / 1ps

module rdp_div
    import rdp_pkg::*;
(
    input  logic  clk,
    input  word_t num,
    input  word_t den,
    output res_t  res
);

    localparam int HB = DW - FB;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] low;
        logic [DW-1:0] md;
        logic [DW-1:0] q;
        logic          neg;
        logic          nneg;
        logic          zero;
        logic          ovf;
    } dstage_t;

    dstage_t st_reg  [0:DW];
    dstage_t st_next [0:DW];
    res_t    res_reg;
    res_t    res_next;
    logic [DW-1:0] mn;
    logic [DW-1:0] md;
    logic [DW:0]   r2  [0:DW-1];
    logic          ge  [0:DW-1];

    always_comb
    begin
        mn = num[DW-1] ? (~num + 1'b1) : num;
        md = den[DW-1] ? (~den + 1'b1) : den;
        st_next[0].rem  = DW'(mn >> HB);
        st_next[0].low  = {mn[HB-1:0], {FB{1'b0}}};
        st_next[0].md   = md;
        st_next[0].q    = '0;
        st_next[0].neg  = num[DW-1] ^ den[DW-1];
        st_next[0].nneg = num[DW-1];
        st_next[0].zero = den == '0;
        st_next[0].ovf  = {{HB{1'b0}}, mn} >= {md, {HB{1'b0}}};
        for (int k = 0; k < DW; k++)
        begin
            r2[k] = {st_reg[k].rem, st_reg[k].low[DW-1]};
            ge[k] = r2[k] >= {1'b0, st_reg[k].md};
            st_next[k+1]     = st_reg[k];
            st_next[k+1].rem = ge[k] ? DW'(r2[k] - {1'b0, st_reg[k].md}) : r2[k][DW-1:0];
            st_next[k+1].low = {st_reg[k].low[DW-2:0], 1'b0};
            st_next[k+1].q   = {st_reg[k].q[DW-2:0], ge[k]};
        end
    end

    always_comb
    begin
        if (st_reg[DW].zero)
        begin
            res_next.sat = 1'b1;
            res_next.val = st_reg[DW].nneg ? MIN_VAL : MAX_VAL;
        end
        else if (st_reg[DW].ovf)
        begin
            res_next.sat = 1'b1;
            res_next.val = st_reg[DW].neg ? MIN_VAL : MAX_VAL;
        end
        else if (st_reg[DW].neg)
        begin
            res_next.sat = st_reg[DW].q[DW-1] && (|st_reg[DW].q[DW-2:0]);
            res_next.val = st_reg[DW].q[DW-1] ? MIN_VAL : word_t'(~st_reg[DW].q + 1'b1);
        end
        else
        begin
            res_next.sat = st_reg[DW].q[DW-1];
            res_next.val = st_reg[DW].q[DW-1] ? MAX_VAL : word_t'(st_reg[DW].q);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DW; k++)
        begin
            st_reg[k] <= st_next[k];
        end
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule
